// File: hw/rtl/sfd_pkg.sv
package sfd_pkg;

    localparam logic [7:0] SYNC_BYTE        = 8'hAA;
    localparam logic [1:0] SYNC_LAST        = 2'd2;   // sync_seen value before the third sync byte
    localparam logic [7:0] COMMA_BYTE       = 8'h2C;
    localparam logic [7:0] MIN_FIELDS_RESET = 8'd12;

    localparam int unsigned ADDR_W = 3;
    localparam logic REG_MIN_FIELDS = 1'b0;           // word index, paddr[2]

    localparam logic KIND_BODY    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_BODY = 3'd2,
        PH_CKLO = 3'd3,
        PH_CKHI = 3'd4
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] field_index;
        logic [7:0] body_length;
        logic       checksum_ok;
        logic       fields_ok;
    } result_t;

endpackage

// File: hw/rtl/sfd_cfg.sv
module sfd_cfg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sfd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output logic [7:0]                 min_fields
);

    logic [7:0] min_fields_reg;
    logic [7:0] min_fields_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready
                    && (paddr[2] == sfd_pkg::REG_MIN_FIELDS);

    always_comb
    begin
        min_fields_next = min_fields_reg;
        if (wr_en)
        begin
            min_fields_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_fields_reg <= sfd_pkg::MIN_FIELDS_RESET;
        end
        else
        begin
            min_fields_reg <= min_fields_next;
        end
    end

    assign prdata     = (paddr[2] == sfd_pkg::REG_MIN_FIELDS) ? {24'd0, min_fields_reg} : 32'd0;
    assign min_fields = min_fields_reg;

endmodule

// File: hw/rtl/sfd_inreg.sv
module sfd_inreg
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       take;

    assign in_ready = !valid_reg || advance;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (take)
        begin
            valid_next = 1'b1;
            byte_next  = in_byte;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

// File: hw/rtl/sfd_frame.sv
module sfd_frame
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    input  logic [7:0]       min_fields,
    output logic             res_valid,
    output sfd_pkg::result_t res
);

    sfd_pkg::phase_t phase_reg;
    sfd_pkg::phase_t phase_next;
    logic [1:0]      sync_seen_reg;
    logic [1:0]      sync_seen_next;
    logic [7:0]      length_held_reg;
    logic [7:0]      length_held_next;
    logic [7:0]      bytes_left_reg;
    logic [7:0]      bytes_left_next;
    logic [15:0]     body_sum_reg;
    logic [15:0]     body_sum_next;
    logic [7:0]      comma_count_reg;
    logic [7:0]      comma_count_next;
    logic            low_match_reg;
    logic            low_match_next;
    logic [8:0]      fields_have;

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        sync_seen_next   = sync_seen_reg;
        length_held_next = length_held_reg;
        bytes_left_next  = bytes_left_reg;
        body_sum_next    = body_sum_reg;
        comma_count_next = comma_count_reg;
        low_match_next   = low_match_reg;
        case (phase_reg)
            sfd_pkg::PH_LEN:
            begin
                length_held_next = rx_byte;
                bytes_left_next  = rx_byte;
                body_sum_next    = 16'd0;
                comma_count_next = 8'd0;
                low_match_next   = 1'b0;
                phase_next       = (rx_byte == 8'd0) ? sfd_pkg::PH_CKLO : sfd_pkg::PH_BODY;
            end
            sfd_pkg::PH_BODY:
            begin
                if ((rx_byte == sfd_pkg::COMMA_BYTE) && (comma_count_reg != 8'hFF))
                begin
                    comma_count_next = comma_count_reg + 8'd1;
                end
                body_sum_next   = body_sum_reg + {8'd0, rx_byte};
                bytes_left_next = bytes_left_reg - 8'd1;
                if (bytes_left_reg == 8'd1)
                begin
                    phase_next = sfd_pkg::PH_CKLO;
                end
            end
            sfd_pkg::PH_CKLO:
            begin
                low_match_next = (rx_byte == body_sum_reg[7:0]);
                phase_next     = sfd_pkg::PH_CKHI;
            end
            sfd_pkg::PH_CKHI:
            begin
                phase_next     = sfd_pkg::PH_HUNT;
                sync_seen_next = 2'd0;
            end
            default:
            begin
                phase_next = sfd_pkg::PH_HUNT;
                if (rx_byte == sfd_pkg::SYNC_BYTE)
                begin
                    if (sync_seen_reg == sfd_pkg::SYNC_LAST)
                    begin
                        sync_seen_next = 2'd0;
                        phase_next     = sfd_pkg::PH_LEN;
                    end
                    else
                    begin
                        sync_seen_next = sync_seen_reg + 2'd1;
                    end
                end
                else
                begin
                    sync_seen_next = 2'd0;
                end
            end
        endcase
    end

    assign fields_have = {1'b0, comma_count_reg} + 9'd1;

    // outputs
    always_comb
    begin
        res_valid       = 1'b0;
        res.kind        = sfd_pkg::KIND_BODY;
        res.data_byte   = 8'd0;
        res.field_index = comma_count_reg;
        res.body_length = length_held_reg;
        res.checksum_ok = 1'b0;
        res.fields_ok   = 1'b0;
        case (phase_reg)
            sfd_pkg::PH_BODY:
            begin
                res_valid     = 1'b1;
                res.data_byte = rx_byte;
            end
            sfd_pkg::PH_CKHI:
            begin
                res_valid       = 1'b1;
                res.kind        = sfd_pkg::KIND_VERDICT;
                res.checksum_ok = low_match_reg && (rx_byte == body_sum_reg[15:8]);
                res.fields_ok   = (fields_have >= {1'b0, min_fields});
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= sfd_pkg::PH_HUNT;
            sync_seen_reg   <= 2'd0;
            length_held_reg <= 8'd0;
            bytes_left_reg  <= 8'd0;
            body_sum_reg    <= 16'd0;
            comma_count_reg <= 8'd0;
            low_match_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            sync_seen_reg   <= sync_seen_next;
            length_held_reg <= length_held_next;
            bytes_left_reg  <= bytes_left_next;
            body_sum_reg    <= body_sum_next;
            comma_count_reg <= comma_count_next;
            low_match_reg   <= low_match_next;
        end
    end

endmodule

// File: hw/rtl/sfd_outreg.sv
module sfd_outreg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             res_valid,
    input  sfd_pkg::result_t res,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output sfd_pkg::result_t out_res
);

    logic             valid_reg;
    logic             valid_next;
    sfd_pkg::result_t res_reg;
    sfd_pkg::result_t res_next;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (load)
        begin
            valid_next = res_valid;
            res_next   = res;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// File: hw/rtl/status_frame_deframer.sv
// Status frame deframer: takes one received byte per request on s_axis, hunts for
// three 0xAA sync bytes, reads a length byte, passes each body byte on m_axis
// (tuser = 0) tagged with its comma-separated field index, then checks the two
// checksum bytes (low, high byte of the 16-bit body sum) and sends one verdict
// request (tuser = 1) with checksum_ok and fields_ok (commas + 1 >= min_fields).
// One byte is taken every clock cycle while m_axis keeps up; a byte runs through
// an input register and the frame logic into the result register, which drives
// m_axis_tvalid. min_fields sits at APB address 0 (reset 12) and is to be written
// only while the block is idle.
module status_frame_deframer
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // [7:0] rx_byte
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [7:0] data_byte, [15:8] field_index, [23:16] body_length,
    // [24] checksum_ok, [25] fields_ok, [31:26] zero
    output logic [31:0]                m_axis_tdata,
    output logic                       m_axis_tuser,   // [0] kind
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sfd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic             held_valid;
    logic [7:0]       held_byte;
    logic             out_free;
    logic             advance;
    logic [7:0]       min_fields;
    logic             res_valid;
    sfd_pkg::result_t res;
    sfd_pkg::result_t out_res;

    assign advance = held_valid && out_free;

    sfd_cfg u_cfg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .min_fields (min_fields)
    );

    sfd_inreg u_inreg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    sfd_frame u_frame
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .rx_byte    (held_byte),
        .min_fields (min_fields),
        .res_valid  (res_valid),
        .res        (res)
    );

    sfd_outreg u_outreg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_valid (res_valid),
        .res       (res),
        .free      (out_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {6'd0, out_res.fields_ok, out_res.checksum_ok,
                           out_res.body_length, out_res.field_index, out_res.data_byte};
    assign m_axis_tuser = out_res.kind;

endmodule

// File: verif/frame_checker.sv
module frame_checker
    import sfd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [31:0]         m_axis_tdata,
    input  logic                m_axis_tuser,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,
    output int                  errors,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow of the deframer state
    logic [7:0]  min_fields_shadow;
    phase_t      hunt_phase;
    logic [1:0]  sync_run;
    logic [7:0]  frame_length;
    logic [7:0]  body_remaining;
    logic [15:0] running_sum;
    logic [7:0]  commas_seen;
    logic        low_ck_matched;

    result_t     body_and_verdict_q[$];

    task automatic note_mismatch(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        result_t r;
        r = '0;
        case (hunt_phase)
            PH_LEN:
            begin
                frame_length   = b;
                body_remaining = b;
                running_sum    = '0;
                commas_seen    = '0;
                low_ck_matched = 1'b0;
                hunt_phase     = (b == 8'd0) ? PH_CKLO : PH_BODY;
            end
            PH_BODY:
            begin
                r.kind        = KIND_BODY;
                r.data_byte   = b;
                r.field_index = commas_seen;
                r.body_length = frame_length;
                body_and_verdict_q.push_back(r);
                // comma count saturates
                if (b == COMMA_BYTE && commas_seen != 8'hFF)
                    commas_seen++;
                running_sum += {8'd0, b};
                body_remaining--;
                if (body_remaining == 8'd0)
                    hunt_phase = PH_CKLO;
            end
            PH_CKLO:
            begin
                low_ck_matched = (b == running_sum[7:0]);
                hunt_phase     = PH_CKHI;
            end
            PH_CKHI:
            begin
                r.kind        = KIND_VERDICT;
                r.field_index = commas_seen;
                r.body_length = frame_length;
                r.checksum_ok = low_ck_matched && (b == running_sum[15:8]);
                r.fields_ok   = ({1'b0, commas_seen} + 9'd1) >= {1'b0, min_fields_shadow};
                body_and_verdict_q.push_back(r);
                hunt_phase = PH_HUNT;
                sync_run   = '0;
            end
            default:
            begin
                hunt_phase = PH_HUNT;
                if (b == SYNC_BYTE)
                begin
                    if (sync_run == SYNC_LAST)
                    begin
                        sync_run   = '0;
                        hunt_phase = PH_LEN;
                    end
                    else
                        sync_run++;
                end
                else
                    sync_run = '0;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            min_fields_shadow = MIN_FIELDS_RESET;
            hunt_phase        = PH_HUNT;
            sync_run          = '0;
            frame_length      = '0;
            body_remaining    = '0;
            running_sum       = '0;
            commas_seen       = '0;
            low_ck_matched    = 1'b0;
            body_and_verdict_q.delete();
            errors            = 0;
            pending           = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (body_and_verdict_q.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected output, expected none actual tuser %0h tdata %0h",
                             $time, m_axis_tuser, m_axis_tdata);
                end
                else
                begin
                    want = body_and_verdict_q.pop_front();
                    note_mismatch("kind", want.kind, m_axis_tuser);
                    note_mismatch("data_byte", want.data_byte, m_axis_tdata[7:0]);
                    note_mismatch("field_index", want.field_index, m_axis_tdata[15:8]);
                    note_mismatch("body_length", want.body_length, m_axis_tdata[23:16]);
                    note_mismatch("checksum_ok", want.checksum_ok, m_axis_tdata[24]);
                    note_mismatch("fields_ok", want.fields_ok, m_axis_tdata[25]);
                    note_mismatch("tdata pad", 0, m_axis_tdata[31:26]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                deframe_byte(s_axis_tdata);
            if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_MIN_FIELDS)
                min_fields_shadow = pwdata[7:0];
            pending = body_and_verdict_q.size();
        end
    end

endmodule

// File: verif/testbench.sv
module testbench;
    import sfd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 8;
    localparam int PHASE_ITEMS = 145;

    localparam logic [7:0] CR_BYTE = 8'h0D;
    localparam logic [7:0] LF_BYTE = 8'h0A;
    localparam logic [ADDR_W-1:0] MIN_FIELDS_ADDR = {REG_MIN_FIELDS, 2'b00};

    // checksum handling for a built frame
    localparam int CK_GOOD   = 0;
    localparam int CK_BAD_LO = 1;
    localparam int CK_BAD_HI = 2;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [31:0]       m_axis_tdata;
    logic              m_axis_tuser;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int                errors;
    int                pending;
    int                cycle_count;
    int                bytes_sent;
    bit                tx_idle;
    bit                rx_idle;
    logic [7:0]        body_bytes[$];

    status_frame_deframer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    frame_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stall before each result while rx_idle is set
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, 5) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // tvalid is left high after a request; a gap or a pause lowers it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_min_fields(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MIN_FIELDS_ADDR;
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic fill_body(input int n, input int comma_pct);
        body_bytes.delete();
        repeat (n)
            body_bytes.push_back(($urandom_range(1, 100) <= comma_pct) ? COMMA_BYTE
                                                                       : 8'($urandom));
    endtask

    task automatic send_frame(input int ck_mode, input bit cut_short);
        logic [15:0] sum;
        logic [7:0]  ck_lo;
        logic [7:0]  ck_hi;
        int          n;
        sum = '0;
        foreach (body_bytes[i])
            sum += {8'd0, body_bytes[i]};
        ck_lo = sum[7:0];
        ck_hi = sum[15:8];
        if (ck_mode == CK_BAD_LO)
            ck_lo ^= 8'($urandom_range(1, 255));
        else if (ck_mode == CK_BAD_HI)
            ck_hi ^= 8'($urandom_range(1, 255));
        n = cut_short ? body_bytes.size() / 2 : body_bytes.size();
        repeat (3) send_byte(SYNC_BYTE);
        send_byte(8'(body_bytes.size()));
        for (int i = 0; i < n; i++)
            send_byte(body_bytes[i]);
        if (!cut_short)
        begin
            send_byte(ck_lo);
            send_byte(ck_hi);
        end
    endtask

    task automatic send_noise();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0:
            begin
                send_byte(CR_BYTE);
                send_byte(LF_BYTE);
            end
            1:
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            2:
            begin
                // sync run broken before the third byte
                b = 8'($urandom);
                if (b == SYNC_BYTE)
                    b = 8'h55;
                repeat ($urandom_range(1, 2)) send_byte(SYNC_BYTE);
                send_byte(b);
            end
            default:
                ;
        endcase
    endtask

    task automatic random_frames(input int budget);
        int start;
        int ck_pick;
        int mode;
        int n;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 39) == 0)
                wait_drained();
            send_noise();
            n = ($urandom_range(0, 39) == 0) ? $urandom_range(21, 255) : $urandom_range(0, 20);
            fill_body(n, $urandom_range(0, 100));
            ck_pick = $urandom_range(0, 9);
            mode = (ck_pick == 0) ? CK_BAD_LO : (ck_pick == 1) ? CK_BAD_HI : CK_GOOD;
            send_frame(mode, $urandom_range(0, 32) == 0);
        end
        fill_body($urandom_range(0, 12), 40);
        send_frame(CK_GOOD, 1'b0);
    endtask

    initial
    begin
        logic [7:0] settings[6];
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        rst_n         = 1'b0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        cycle_count   = 0;
        bytes_sent    = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at reset min_fields
        send_byte(SYNC_BYTE);
        send_byte(SYNC_BYTE);
        send_byte(8'h55);
        body_bytes.delete();
        send_frame(CK_GOOD, 1'b0);
        send_byte(CR_BYTE);
        send_byte(LF_BYTE);
        body_bytes = '{8'h00, COMMA_BYTE, 8'hFF, COMMA_BYTE};
        send_frame(CK_GOOD, 1'b0);
        body_bytes = '{COMMA_BYTE};
        send_frame(CK_BAD_LO, 1'b0);
        body_bytes = '{8'h01};
        send_frame(CK_BAD_HI, 1'b0);
        wait_drained();

        settings = '{8'd1, 8'd255, 8'd0, MIN_FIELDS_RESET, 8'($urandom_range(2, 16)), 8'd5};
        foreach (settings[p])
        begin
            write_min_fields(settings[p]);
            if (settings[p] == 8'd1)
            begin
                // length 0xAA: the fourth sync-looking byte is the length
                fill_body(8'hAA, 20);
                send_frame(CK_GOOD, 1'b0);
            end
            if (settings[p] == 8'd255)
            begin
                // comma count saturates, then one short of the limit
                body_bytes.delete();
                repeat (255) body_bytes.push_back(COMMA_BYTE);
                send_frame(CK_GOOD, 1'b0);
                fill_body(255, 0);
                for (int i = 0; i < 253; i++)
                    body_bytes[i] = COMMA_BYTE;
                send_frame(CK_GOOD, 1'b0);
            end
            random_frames(PHASE_ITEMS);
            wait_drained();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
